// ===== design/thadc_pkg.sv =====
// Package for the thermistor ADC to temperature block: widths, register
// indexes and the resistance/temperature ROM. No dependencies.
package thadc_pkg;

   localparam int unsigned AdcBits      = 12;
   localparam int unsigned TableEntries = 114;
   localparam int unsigned RefBits      = 20;
   localparam int unsigned ResBits      = 20;
   localparam int unsigned TempBits     = 16;
   localparam int unsigned CsrIdxBits   = 8;
   localparam int unsigned CsrDataBits  = 32;

   localparam logic [CsrIdxBits-1:0] CSR_REF_OHMS   = 8'd0;
   localparam logic [CsrIdxBits-1:0] CSR_FAHRENHEIT = 8'd1;

   localparam logic [RefBits-1:0] RefOhmsReset = 20'd10000;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture sample, start resistance division
      logic div_step;    // one restoring-division step
      logic scan_load;   // load ROM interval at scan index
      logic scan_next;   // advance scan index
      logic interp_mul;  // form interpolation numerator
      logic fdiv_init;   // set up final division
      logic fdiv_step;   // one final-division step
      logic finish;      // latch result
   } thadc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic rail;        // sample at 0 or full scale
      logic range_bad;   // resistance outside table
      logic hit;         // current interval holds resistance
      logic scan_end;    // last interval reached
   } thadc_sts_type;

   function automatic logic [ResBits-1:0] res_rom(input logic [7:0] idx);
      logic [ResBits-1:0] v;
      unique case (idx)
         8'd0: v=323839; 8'd1: v=300974; 8'd2: v=279880; 8'd3: v=260410;
         8'd4: v=242427; 8'd5: v=225809; 8'd6: v=210443; 8'd7: v=196227;
         8'd8: v=183068; 8'd9: v=170775; 8'd10: v=159488; 8'd11: v=149024;
         8'd12: v=139316; 8'd13: v=130306; 8'd14: v=121939; 8'd15: v=114165;
         8'd16: v=106939; 8'd17: v=100218; 8'd18: v=93909; 8'd19: v=88090;
         8'd20: v=82670; 8'd21: v=77620; 8'd22: v=72914; 8'd23: v=68518;
         8'd24: v=64419; 8'd25: v=60592; 8'd26: v=57017; 8'd27: v=53647;
         8'd28: v=50526; 8'd29: v=47606; 8'd30: v=44874; 8'd31: v=42317;
         8'd32: v=39921; 8'd33: v=37676; 8'd34: v=35573; 8'd35: v=33599;
         8'd36: v=31732; 8'd37: v=29996; 8'd38: v=28365; 8'd39: v=26834;
         8'd40: v=25395; 8'd41: v=24042; 8'd42: v=22770; 8'd43: v=21573;
         8'd44: v=20446; 8'd45: v=19376; 8'd46: v=18378; 8'd47: v=17437;
         8'd48: v=16550; 8'd49: v=15714; 8'd50: v=14925; 8'd51: v=14180;
         8'd52: v=13478; 8'd53: v=12814; 8'd54: v=12182; 8'd55: v=11590;
         8'd56: v=11030; 8'd57: v=10501; 8'd58: v=10000; 8'd59: v=9526;
         8'd60: v=9078; 8'd61: v=8653; 8'd62: v=8251; 8'd63: v=7866;
         8'd64: v=7505; 8'd65: v=7163; 8'd66: v=6838; 8'd67: v=6530;
         8'd68: v=6238; 8'd69: v=5960; 8'd70: v=5697; 8'd71: v=5447;
         8'd72: v=5207; 8'd73: v=4981; 8'd74: v=4766; 8'd75: v=4561;
         8'd76: v=4367; 8'd77: v=4182; 8'd78: v=4006; 8'd79: v=3838;
         8'd80: v=3679; 8'd81: v=3525; 8'd82: v=3380; 8'd83: v=3242;
         8'd84: v=3114; 8'd85: v=2985; 8'd86: v=2865; 8'd87: v=2751;
         8'd88: v=2642; 8'd89: v=2538; 8'd90: v=2438; 8'd91: v=2343;
         8'd92: v=2252; 8'd93: v=2165; 8'd94: v=2082; 8'd95: v=2003;
         8'd96: v=1927; 8'd97: v=1855; 8'd98: v=1785; 8'd99: v=1718;
         8'd100: v=1655; 8'd101: v=1594; 8'd102: v=1536; 8'd103: v=1480;
         8'd104: v=1427; 8'd105: v=1375; 8'd106: v=1326; 8'd107: v=1279;
         8'd108: v=1234; 8'd109: v=1190; 8'd110: v=1149; 8'd111: v=1109;
         8'd112: v=1070; 8'd113: v=1034;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [TempBits-1:0] temp_rom(input logic [7:0] idx);
      logic signed [TempBits-1:0] v;
      unique case (idx)
         8'd0: v=-3944; 8'd1: v=-3833; 8'd2: v=-3722; 8'd3: v=-3611;
         8'd4: v=-3500; 8'd5: v=-3389; 8'd6: v=-3278; 8'd7: v=-3167;
         8'd8: v=-3056; 8'd9: v=-2944; 8'd10: v=-2833; 8'd11: v=-2722;
         8'd12: v=-2611; 8'd13: v=-2500; 8'd14: v=-2389; 8'd15: v=-2278;
         8'd16: v=-2167; 8'd17: v=-2056; 8'd18: v=-1944; 8'd19: v=-1833;
         8'd20: v=-1722; 8'd21: v=-1611; 8'd22: v=-1500; 8'd23: v=-1389;
         8'd24: v=-1278; 8'd25: v=-1167; 8'd26: v=-1056; 8'd27: v=-944;
         8'd28: v=-833; 8'd29: v=-722; 8'd30: v=-611; 8'd31: v=-500;
         8'd32: v=-389; 8'd33: v=-278; 8'd34: v=-167; 8'd35: v=-56;
         8'd36: v=56; 8'd37: v=167; 8'd38: v=278; 8'd39: v=389;
         8'd40: v=500; 8'd41: v=611; 8'd42: v=722; 8'd43: v=833;
         8'd44: v=944; 8'd45: v=1056; 8'd46: v=1167; 8'd47: v=1278;
         8'd48: v=1389; 8'd49: v=1500; 8'd50: v=1611; 8'd51: v=1722;
         8'd52: v=1833; 8'd53: v=1944; 8'd54: v=2056; 8'd55: v=2167;
         8'd56: v=2278; 8'd57: v=2389; 8'd58: v=2500; 8'd59: v=2611;
         8'd60: v=2722; 8'd61: v=2833; 8'd62: v=2944; 8'd63: v=3056;
         8'd64: v=3167; 8'd65: v=3278; 8'd66: v=3389; 8'd67: v=3500;
         8'd68: v=3614; 8'd69: v=3722; 8'd70: v=3833; 8'd71: v=3944;
         8'd72: v=4056; 8'd73: v=4167; 8'd74: v=4278; 8'd75: v=4389;
         8'd76: v=4500; 8'd77: v=4611; 8'd78: v=4722; 8'd79: v=4833;
         8'd80: v=4944; 8'd81: v=5056; 8'd82: v=5167; 8'd83: v=5278;
         8'd84: v=5389; 8'd85: v=5500; 8'd86: v=5614; 8'd87: v=5722;
         8'd88: v=5833; 8'd89: v=5944; 8'd90: v=6056; 8'd91: v=6167;
         8'd92: v=6278; 8'd93: v=6389; 8'd94: v=6500; 8'd95: v=6614;
         8'd96: v=6722; 8'd97: v=6833; 8'd98: v=6944; 8'd99: v=7056;
         8'd100: v=7167; 8'd101: v=7278; 8'd102: v=7389; 8'd103: v=7500;
         8'd104: v=7614; 8'd105: v=7722; 8'd106: v=7833; 8'd107: v=7944;
         8'd108: v=8056; 8'd109: v=8167; 8'd110: v=8278; 8'd111: v=8389;
         8'd112: v=8500; 8'd113: v=8611;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/thermistor_adc_to_temperature.sv =====
// Thermistor ADC to temperature top level: config registers, output register.
// Flow: divide and range-check, scan the table intervals, then interpolate, divide again and register the result.
// One sample at a time: a new sample is taken only when idle and no result is waiting.
// Out-of-range samples skip the table scan and finish after the range check.
// Synchronous active-high reset: ref 10000 ohms, Fahrenheit output, channels empty.
// Depends on thadc_pkg, thadc_ctrl, thadc_datapath.
module thermistor_adc_to_temperature #(
   parameter int unsigned ADC_BITS      = thadc_pkg::AdcBits,
   parameter int unsigned TABLE_ENTRIES = thadc_pkg::TableEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [((ADC_BITS+7)/8)*8-1:0] req_tdata,  // [ADC_BITS-1:0] adc_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,                    // [15:0] temperature_centi
   output logic        rsp_tuser,                    // [0] out_of_range
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [thadc_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [thadc_pkg::CsrDataBits-1:0] csr_data
);
   import thadc_pkg::*;

   logic [RefBits-1:0] ref_ff;
   logic               fahr_ff;
   logic               busy, done, bad;
   thadc_cmd_type      cmd;
   thadc_sts_type      sts;
   logic signed [TempBits-1:0] temp;
   logic               rvalid_ff;
   logic [15:0]        rdata_ff;
   logic               ruser_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy && !rvalid_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff  <= RefOhmsReset;
         fahr_ff <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == CSR_REF_OHMS) ref_ff <= csr_data[RefBits-1:0];
         else if (csr_index == CSR_FAHRENHEIT) fahr_ff <= csr_data[0];
      end
   end

   thadc_ctrl #(.ADC_BITS(ADC_BITS)) u_ctrl (
      .clock(clock), .reset(reset), .start(req_tvalid && req_tready),
      .busy(busy), .sts(sts), .cmd(cmd), .done(done), .bad(bad));

   thadc_datapath #(.ADC_BITS(ADC_BITS), .TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock(clock), .adc_sample(req_tdata[ADC_BITS-1:0]), .ref_ohms(ref_ff),
      .fahrenheit(fahr_ff), .cmd(cmd), .sts(sts), .temp(temp));

   // result register, hold until transfer
   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else if (done) rvalid_ff <= 1'b1;
      else if (rsp_tready) rvalid_ff <= 1'b0;
      if (done) begin
         rdata_ff <= bad ? 16'd0 : temp;
         ruser_ff <= bad;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

endmodule

// ===== design/thadc_datapath.sv =====
// Datapath: sample capture, serial resistance divider, ROM scan, interpolation
// multiply and serial final divider. Depends on thadc_pkg.
module thadc_datapath #(
   parameter int unsigned ADC_BITS      = thadc_pkg::AdcBits,
   parameter int unsigned TABLE_ENTRIES = thadc_pkg::TableEntries
) (
   input  logic                                 clock,
   input  logic [ADC_BITS-1:0]                  adc_sample,
   input  logic [thadc_pkg::RefBits-1:0]        ref_ohms,
   input  logic                                 fahrenheit,
   input  thadc_pkg::thadc_cmd_type             cmd,
   output thadc_pkg::thadc_sts_type             sts,
   output logic signed [thadc_pkg::TempBits-1:0] temp
);
   import thadc_pkg::*;

   localparam int unsigned QW  = RefBits + ADC_BITS;  // dividend width
   localparam int unsigned IW  = $clog2(TABLE_ENTRIES);
   localparam logic [ADC_BITS-1:0] AdcMax = {ADC_BITS{1'b1}};
   localparam int unsigned NW  = 48;                  // numerator width
   localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 2);

   logic [ADC_BITS-1:0]     adc_ff;
   logic [ADC_BITS-1:0]     dvs_ff;
   logic [QW-1:0]           quo_ff;   // dividend shifts out, quotient shifts in
   logic [ADC_BITS:0]       rem_ff;
   logic [IW-1:0]           idx_ff;
   logic [ResBits-1:0]      hi_ff, lo_ff;
   logic signed [TempBits-1:0] t1_ff, t2_ff;
   logic signed [NW-1:0]    num_ff;   // signed dividend, final division
   logic [NW-1:0]           fq_ff;    // magnitude quotient shift register
   logic [NW:0]             frem_ff;
   logic [NW-1:0]           fden_ff;
   logic                    fneg_ff;
   logic signed [TempBits-1:0] temp_ff;

   logic [ADC_BITS:0]   rem_try;
   logic [QW-1:0]       res_full;
   logic [NW:0]         frem_try;
   logic [NW-1:0]       den;
   logic signed [NW-1:0] num_raw, fnum;
   logic signed [NW-1:0] qmag;

   assign rem_try  = {rem_ff[ADC_BITS-1:0], quo_ff[QW-1]};
   assign res_full = quo_ff;
   assign frem_try = {frem_ff[NW-1:0], fq_ff[NW-1]};

   // interpolation: num = t1*den + (hi-r)*(t2-t1)
   assign den = NW'(hi_ff - lo_ff);
   assign num_raw = NW'(signed'(t1_ff)) * signed'(den)
      + signed'(NW'(hi_ff - res_full[ResBits-1:0])) * NW'(signed'(t2_ff - t1_ff));
   assign fnum = fahrenheit ? num_raw * NW'(9) + signed'(den) * NW'(16000) : num_raw;
   assign qmag = signed'(fq_ff);

   // status
   always_comb begin
      sts.rail      = (adc_ff == '0) || (adc_ff == AdcMax);
      sts.range_bad = (res_full > QW'(res_rom(8'(0))))
         || (res_full < QW'(res_rom(8'(TABLE_ENTRIES - 1))));
      sts.hit       = (res_full[ResBits-1:0] <= hi_ff) && (res_full[ResBits-1:0] >= lo_ff);
      sts.scan_end  = (idx_ff == LastIdx);
   end

   always_ff @(posedge clock) begin
      // capture sample, load dividend ref*adc
      if (cmd.load) begin
         adc_ff <= adc_sample;
         dvs_ff <= AdcMax - adc_sample;
         quo_ff <= QW'(ref_ohms) * QW'(adc_sample);
         rem_ff <= '0;
         idx_ff <= '0;
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         if (rem_try >= {1'b0, dvs_ff}) begin
            rem_ff <= rem_try - {1'b0, dvs_ff};
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_try;
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.scan_load) begin
         hi_ff <= res_rom(8'(idx_ff));
         lo_ff <= res_rom(8'(idx_ff) + 8'd1);
         t1_ff <= temp_rom(8'(idx_ff));
         t2_ff <= temp_rom(8'(idx_ff) + 8'd1);
      end
      if (cmd.scan_next) idx_ff <= idx_ff + IW'(1);
      if (cmd.interp_mul) num_ff <= fnum;
      // final division setup: magnitude divide, sign fixed at the end
      if (cmd.fdiv_init) begin
         fneg_ff <= num_ff[NW-1];
         fq_ff   <= num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
         frem_ff <= '0;
         fden_ff <= fahrenheit ? den * NW'(5) : den;
      end
      if (cmd.fdiv_step) begin
         if (frem_try >= {1'b0, fden_ff}) begin
            frem_ff <= frem_try - {1'b0, fden_ff};
            fq_ff   <= {fq_ff[NW-2:0], 1'b1};
         end else begin
            frem_ff <= frem_try;
            fq_ff   <= {fq_ff[NW-2:0], 1'b0};
         end
      end
      if (cmd.finish) temp_ff <= fneg_ff ? TempBits'(-qmag) : TempBits'(qmag);
   end

   assign temp = temp_ff;

endmodule

// ===== design/thadc_ctrl.sv =====
// Controller: sequences division, table scan, interpolation and result
// handshake. Depends on thadc_pkg.
module thadc_ctrl #(
   parameter int unsigned ADC_BITS = thadc_pkg::AdcBits
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  thadc_pkg::thadc_sts_type sts,
   output thadc_pkg::thadc_cmd_type cmd,
   output logic                     done,
   output logic                     bad
);
   import thadc_pkg::*;

   localparam int unsigned QW = RefBits + ADC_BITS;
   localparam int unsigned NW = 48;
   localparam int unsigned CW = $clog2(NW + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_CHECK, ST_LOAD, ST_TEST, ST_MUL, ST_FINIT, ST_FDIV,
      ST_FIN, ST_DONE
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] cnt_ff;
   logic          bad_ff;

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);
   assign bad  = bad_ff;

   always_comb begin
      cmd = '0;
      cmd.load       = (state_ff == ST_IDLE) && start;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.scan_load  = (state_ff == ST_LOAD);
      cmd.scan_next  = (state_ff == ST_TEST) && !sts.hit;
      cmd.interp_mul = (state_ff == ST_MUL);
      cmd.fdiv_init  = (state_ff == ST_FINIT);
      cmd.fdiv_step  = (state_ff == ST_FDIV);
      cmd.finish     = (state_ff == ST_FIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         bad_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (start) begin
               state_ff <= ST_DIV;
               cnt_ff   <= CW'(QW - 1);
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == '0) state_ff <= ST_CHECK;
            end
            ST_CHECK: if (sts.rail || sts.range_bad) begin
               bad_ff   <= 1'b1;
               state_ff <= ST_DONE;
            end else begin
               bad_ff   <= 1'b0;
               state_ff <= ST_LOAD;
            end
            ST_LOAD: state_ff <= ST_TEST;
            // advance through intervals until one holds the resistance
            ST_TEST: if (sts.hit) state_ff <= ST_MUL;
               else if (sts.scan_end) begin
                  bad_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else state_ff <= ST_LOAD;
            ST_MUL: state_ff <= ST_FINIT;
            ST_FINIT: begin
               state_ff <= ST_FDIV;
               cnt_ff   <= CW'(NW - 1);
            end
            ST_FDIV: begin
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == '0) state_ff <= ST_FIN;
            end
            ST_FIN:  state_ff <= ST_DONE;
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy)) else $error("done without work");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy) else $error("load did not start work");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.div_step, cmd.fdiv_step, cmd.scan_load, cmd.interp_mul}))
      else $error("overlapping datapath commands");

endmodule
